/* hw/rtl/assert_macros.svh */
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define CSM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// checked at every edge, reset included
`define CSM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/csm_pkg.sv */
package csm_pkg;

   localparam int ActionWidth    = 3;
   localparam int SeqWidth       = 32;
   localparam int WinWidth       = 16;
   localparam int CountWidth     = 32;
   localparam int StateCodeWidth = 4;
   localparam int KindWidth      = 3;
   localparam int CsrIndexWidth  = 1;
   localparam int CsrDataWidth   = 32;
   localparam logic [WinWidth-1:0] LocalWindowReset = 16'd64;

   typedef enum logic [ActionWidth-1:0] {
      ACT_LISTEN  = 3'd0,
      ACT_CONNECT = 3'd1,
      ACT_CLOSE   = 3'd2,
      ACT_RX_SYN  = 3'd3,
      ACT_RX_SYNACK = 3'd4,
      ACT_RX_ACK  = 3'd5,
      ACT_RX_FIN  = 3'd6
   } op_type;

   typedef enum logic [KindWidth-1:0] {
      KIND_NONE   = 3'd0,
      KIND_SYN    = 3'd1,
      KIND_SYNACK = 3'd2,
      KIND_ACK    = 3'd3,
      KIND_FIN    = 3'd4
   } send_kind_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_START_SEQ    = 1'b0,
      CSR_LOCAL_WINDOW = 1'b1
   } csr_index_type;

   typedef enum logic [9:0] {
      ST_CLOSED     = 10'b00_0000_0001,
      ST_LISTEN     = 10'b00_0000_0010,
      ST_SYN_SENT   = 10'b00_0000_0100,
      ST_SYN_RCVD   = 10'b00_0000_1000,
      ST_ESTAB      = 10'b00_0001_0000,
      ST_FIN_SENT   = 10'b00_0010_0000,
      ST_FIN_WAIT_2 = 10'b00_0100_0000,
      ST_TIME_WAIT  = 10'b00_1000_0000,
      ST_PEER_FIN   = 10'b01_0000_0000,
      ST_FINAL_ACK  = 10'b10_0000_0000
   } conn_state_type;

   // classified event held in the queue
   typedef struct packed {
      logic                known;
      op_type              op;
      logic [SeqWidth-1:0] seq_inc;
      logic [SeqWidth-1:0] frame_ack;
      logic [WinWidth-1:0] frame_window;
   } entry_type;

   function automatic logic [StateCodeWidth-1:0] state_code(conn_state_type st);
      logic [StateCodeWidth-1:0] code;
      case (st)
         ST_CLOSED:     code = 4'd0;
         ST_LISTEN:     code = 4'd1;
         ST_SYN_SENT:   code = 4'd2;
         ST_SYN_RCVD:   code = 4'd3;
         ST_ESTAB:      code = 4'd4;
         ST_FIN_SENT:   code = 4'd5;
         ST_FIN_WAIT_2: code = 4'd6;
         ST_TIME_WAIT:  code = 4'd7;
         ST_PEER_FIN:   code = 4'd8;
         ST_FINAL_ACK:  code = 4'd9;
         default:       code = 4'd0;
      endcase
      return code;
   endfunction

   // allowed transition table
   function automatic logic may_go(conn_state_type from, conn_state_type to);
      logic [9:0] mask;
      case (from)
         ST_CLOSED:     mask = ST_LISTEN | ST_SYN_SENT;
         ST_LISTEN:     mask = ST_SYN_RCVD;
         ST_SYN_SENT:   mask = ST_ESTAB;
         ST_SYN_RCVD:   mask = ST_ESTAB;
         ST_ESTAB:      mask = ST_FIN_SENT | ST_PEER_FIN;
         ST_FIN_SENT:   mask = ST_CLOSED | ST_FIN_WAIT_2 | ST_TIME_WAIT;
         ST_FIN_WAIT_2: mask = ST_CLOSED | ST_TIME_WAIT;
         ST_TIME_WAIT:  mask = ST_CLOSED;
         ST_PEER_FIN:   mask = ST_FINAL_ACK;
         ST_FINAL_ACK:  mask = ST_CLOSED;
         default:       mask = '0;
      endcase
      return (mask & to) != '0;
   endfunction

endpackage

/* hw/rtl/csm_intf.sv */
interface csm_req_if;
   logic                              valid;
   logic                              ready;
   logic [csm_pkg::ActionWidth-1:0]   action;
   logic [csm_pkg::SeqWidth-1:0]      frame_seq;
   logic [csm_pkg::SeqWidth-1:0]      frame_ack;
   logic [csm_pkg::WinWidth-1:0]      frame_window;

   modport source (output valid, action, frame_seq, frame_ack, frame_window, input ready);
   modport sink (input valid, action, frame_seq, frame_ack, frame_window, output ready);
endinterface

interface csm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                accepted;
   logic [csm_pkg::StateCodeWidth-1:0]  conn_state;
   logic [csm_pkg::KindWidth-1:0]       send_kind;
   logic [csm_pkg::SeqWidth-1:0]        send_seq;
   logic [csm_pkg::SeqWidth-1:0]        send_ack;
   logic [csm_pkg::WinWidth-1:0]        send_window;
   logic [csm_pkg::WinWidth-1:0]        remote_window;
   logic [csm_pkg::CountWidth-1:0]      sent_count;
   logic [csm_pkg::CountWidth-1:0]      recv_count;

   modport source (output valid, accepted, conn_state, send_kind, send_seq, send_ack,
                   send_window, remote_window, sent_count, recv_count, input ready);
   modport sink (input valid, accepted, conn_state, send_kind, send_seq, send_ack,
                 send_window, remote_window, sent_count, recv_count, output ready);
endinterface

interface csm_csr_if;
   logic                                valid;
   logic                                ready;
   logic [csm_pkg::CsrIndexWidth-1:0]   index;
   logic [csm_pkg::CsrDataWidth-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/csm_front.sv */
module csm_front (
   csm_req_if.sink              req_ch,
   output logic                 push_valid,
   input  logic                 push_ready,
   output csm_pkg::entry_type   push_entry
);

   csm_pkg::op_type op;
   logic            known;

   always_comb begin
      op    = csm_pkg::op_type'(req_ch.action);
      known = 1'b1;
      case (op)
         csm_pkg::ACT_LISTEN,
         csm_pkg::ACT_CONNECT,
         csm_pkg::ACT_CLOSE,
         csm_pkg::ACT_RX_SYN,
         csm_pkg::ACT_RX_SYNACK,
         csm_pkg::ACT_RX_ACK,
         csm_pkg::ACT_RX_FIN: known = 1'b1;
         default:             known = 1'b0;
      endcase
   end

   assign push_valid              = req_ch.valid;
   assign req_ch.ready            = push_ready;
   assign push_entry.known        = known;
   assign push_entry.op           = op;
   assign push_entry.seq_inc      = req_ch.frame_seq + csm_pkg::SeqWidth'(1);
   assign push_entry.frame_ack    = req_ch.frame_ack;
   assign push_entry.frame_window = req_ch.frame_window;

endmodule

/* hw/rtl/csm_queue.sv */
module csm_queue #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  csm_pkg::entry_type  push_entry,
   output logic                pop_valid,
   input  logic                pop_ready,
   output csm_pkg::entry_type  pop_entry
);

   localparam int PtrWidth   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CountWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0]   LastPtr = PtrWidth'(DEPTH - 1);
   localparam logic [CountWidth-1:0] Full    = CountWidth'(DEPTH);

   csm_pkg::entry_type    mem_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  push, pop;

   assign push_ready = count_ff != Full;
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_entry  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrWidth'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrWidth'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CountWidth'(1);
         2'b01:   count_in = count_ff - CountWidth'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* hw/rtl/csm_back.sv */
module csm_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 pop_valid,
   output logic                                 pop_ready,
   input  csm_pkg::entry_type                   pop_entry,
   input  logic [csm_pkg::WinWidth-1:0]         local_window,
   csm_rsp_if.source                            rsp_ch
);

   csm_pkg::conn_state_type               state_ff, state_in;
   logic [csm_pkg::SeqWidth-1:0]          local_seq_ff, local_seq_in;
   logic [csm_pkg::SeqWidth-1:0]          expected_ack_ff, expected_ack_in;
   logic [csm_pkg::WinWidth-1:0]          peer_window_ff, peer_window_in;
   logic [csm_pkg::CountWidth-1:0]        frames_out_ff, frames_out_in;
   logic [csm_pkg::CountWidth-1:0]        frames_in_ff, frames_in_in;

   logic                                  rsp_valid_ff;
   logic                                  accepted_ff;
   logic [csm_pkg::StateCodeWidth-1:0]    conn_state_ff;
   csm_pkg::send_kind_type                send_kind_ff;
   logic [csm_pkg::SeqWidth-1:0]          send_seq_ff;
   logic [csm_pkg::SeqWidth-1:0]          send_ack_ff;
   logic [csm_pkg::WinWidth-1:0]          send_window_ff;

   logic                                  accepted;
   csm_pkg::send_kind_type                kind;
   logic [csm_pkg::SeqWidth-1:0]          sseq, sack;
   logic                                  ack_match;
   logic                                  pop;

   assign pop_ready = !rsp_valid_ff || rsp_ch.ready;
   assign pop       = pop_valid && pop_ready;
   assign ack_match = pop_entry.frame_ack == local_seq_ff + csm_pkg::SeqWidth'(1);

   always_comb begin
      state_in        = state_ff;
      local_seq_in    = local_seq_ff;
      expected_ack_in = expected_ack_ff;
      peer_window_in  = peer_window_ff;
      frames_out_in   = frames_out_ff;
      frames_in_in    = frames_in_ff;
      accepted        = 1'b0;
      kind            = csm_pkg::KIND_NONE;
      sseq            = '0;
      sack            = '0;
      if (pop_entry.known) begin
         case (pop_entry.op)
            csm_pkg::ACT_LISTEN: begin
               if (csm_pkg::may_go(state_ff, csm_pkg::ST_LISTEN)) begin
                  state_in = csm_pkg::ST_LISTEN;
                  accepted = 1'b1;
               end
            end
            csm_pkg::ACT_CONNECT: begin
               if (state_ff == csm_pkg::ST_CLOSED &&
                   csm_pkg::may_go(state_ff, csm_pkg::ST_SYN_SENT)) begin
                  state_in      = csm_pkg::ST_SYN_SENT;
                  kind          = csm_pkg::KIND_SYN;
                  sseq          = local_seq_ff;
                  frames_out_in = frames_out_ff + csm_pkg::CountWidth'(1);
                  accepted      = 1'b1;
               end
            end
            csm_pkg::ACT_CLOSE: begin
               accepted = 1'b1;
               if (state_ff == csm_pkg::ST_ESTAB || state_ff == csm_pkg::ST_PEER_FIN) begin
                  state_in      = (state_ff == csm_pkg::ST_ESTAB) ?
                                  csm_pkg::ST_FIN_SENT : csm_pkg::ST_FINAL_ACK;
                  kind          = csm_pkg::KIND_FIN;
                  sseq          = local_seq_ff;
                  sack          = expected_ack_ff;
                  frames_out_in = frames_out_ff + csm_pkg::CountWidth'(1);
                  local_seq_in  = local_seq_ff + csm_pkg::SeqWidth'(1);
               end else if (state_ff != csm_pkg::ST_CLOSED &&
                            state_ff != csm_pkg::ST_FINAL_ACK &&
                            csm_pkg::may_go(state_ff, csm_pkg::ST_CLOSED)) begin
                  state_in = csm_pkg::ST_CLOSED;
               end
            end
            csm_pkg::ACT_RX_SYN: begin
               if (state_ff == csm_pkg::ST_LISTEN) begin
                  state_in        = csm_pkg::ST_SYN_RCVD;
                  expected_ack_in = pop_entry.seq_inc;
                  peer_window_in  = pop_entry.frame_window;
                  kind            = csm_pkg::KIND_SYNACK;
                  sseq            = local_seq_ff;
                  sack            = pop_entry.seq_inc;
                  frames_out_in   = frames_out_ff + csm_pkg::CountWidth'(1);
                  accepted        = 1'b1;
               end
            end
            csm_pkg::ACT_RX_SYNACK: begin
               if (state_ff == csm_pkg::ST_SYN_SENT && ack_match) begin
                  state_in        = csm_pkg::ST_ESTAB;
                  expected_ack_in = pop_entry.seq_inc;
                  peer_window_in  = pop_entry.frame_window;
                  kind            = csm_pkg::KIND_ACK;
                  sseq            = local_seq_ff;
                  sack            = pop_entry.seq_inc;
                  frames_out_in   = frames_out_ff + csm_pkg::CountWidth'(1);
                  accepted        = 1'b1;
               end
            end
            csm_pkg::ACT_RX_ACK: begin
               if (state_ff == csm_pkg::ST_SYN_RCVD) begin
                  if (ack_match) begin
                     state_in       = csm_pkg::ST_ESTAB;
                     peer_window_in = pop_entry.frame_window;
                     frames_in_in   = frames_in_ff + csm_pkg::CountWidth'(1);
                     accepted       = 1'b1;
                  end
               end else if (state_ff == csm_pkg::ST_ESTAB) begin
                  expected_ack_in = pop_entry.seq_inc;
                  peer_window_in  = pop_entry.frame_window;
                  frames_in_in    = frames_in_ff + csm_pkg::CountWidth'(1);
                  accepted        = 1'b1;
               end
            end
            csm_pkg::ACT_RX_FIN: begin
               if (state_ff == csm_pkg::ST_ESTAB || state_ff == csm_pkg::ST_FIN_SENT) begin
                  state_in        = (state_ff == csm_pkg::ST_ESTAB) ?
                                    csm_pkg::ST_PEER_FIN : csm_pkg::ST_TIME_WAIT;
                  expected_ack_in = pop_entry.seq_inc;
                  kind            = csm_pkg::KIND_ACK;
                  sseq            = local_seq_ff;
                  sack            = pop_entry.seq_inc;
                  frames_out_in   = frames_out_ff + csm_pkg::CountWidth'(1);
                  frames_in_in    = frames_in_ff + csm_pkg::CountWidth'(1);
                  accepted        = 1'b1;
               end
            end
            default: begin
               accepted = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= csm_pkg::ST_CLOSED;
         local_seq_ff    <= '0;
         expected_ack_ff <= '0;
         peer_window_ff  <= '0;
         frames_out_ff   <= '0;
         frames_in_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (pop) begin
            state_ff        <= state_in;
            local_seq_ff    <= local_seq_in;
            expected_ack_ff <= expected_ack_in;
            peer_window_ff  <= peer_window_in;
            frames_out_ff   <= frames_out_in;
            frames_in_ff    <= frames_in_in;
            rsp_valid_ff    <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         accepted_ff    <= accepted;
         conn_state_ff  <= csm_pkg::state_code(state_in);
         send_kind_ff   <= kind;
         send_seq_ff    <= sseq;
         send_ack_ff    <= sack;
         send_window_ff <= (kind != csm_pkg::KIND_NONE) ? local_window : '0;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.accepted      = accepted_ff;
   assign rsp_ch.conn_state    = conn_state_ff;
   assign rsp_ch.send_kind     = send_kind_ff;
   assign rsp_ch.send_seq      = send_seq_ff;
   assign rsp_ch.send_ack      = send_ack_ff;
   assign rsp_ch.send_window   = send_window_ff;
   assign rsp_ch.remote_window = peer_window_ff;
   assign rsp_ch.sent_count    = frames_out_ff;
   assign rsp_ch.recv_count    = frames_in_ff;

endmodule

/* hw/rtl/connection_state_machine.sv */
// TCP-style connection endpoint with ten states. Each event word on req_ch (a local
// listen, connect or close, or a received SYN, SYN-ACK, ACK or FIN) yields exactly one
// word on rsp_ch, in order, with acceptance, the new state, the frame to send and the
// frame counters. The block takes one event per clock cycle while rsp_ch is taken every
// cycle: events are decoded into a QUEUE_DEPTH-entry queue and the connection state
// updates as each event leaves it. An event waits in the queue, and its result word is
// registered in the output register and offered from there. While rsp_ch
// stalls, the queue and the output register fill and req_ch.ready drops; it rises again
// the cycle after the first word leaves. The local window register (index 1) sets the
// window of every sent frame; writes to the initial sequence register (index 0) are
// accepted without effect; reset clears the local sequence, so it always starts at zero.
module connection_state_machine #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   csm_req_if.sink    req_ch,
   csm_rsp_if.source  rsp_ch,
   csm_csr_if.sink    csr_ch
);

   logic                             push_valid, push_ready;
   logic                             pop_valid, pop_ready;
   csm_pkg::entry_type               push_entry, pop_entry;
   logic [csm_pkg::WinWidth-1:0]     local_window_ff, local_window_in;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      local_window_in = local_window_ff;
      if (csr_ch.valid && csr_ch.index == csm_pkg::CSR_LOCAL_WINDOW) begin
         local_window_in = csr_ch.data[csm_pkg::WinWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_window_ff <= csm_pkg::LocalWindowReset;
      end else begin
         local_window_ff <= local_window_in;
      end
   end

   csm_front u_front (
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   csm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   csm_back u_back (
      .clock        (clock),
      .reset        (reset),
      .pop_valid    (pop_valid),
      .pop_ready    (pop_ready),
      .pop_entry    (pop_entry),
      .local_window (local_window_ff),
      .rsp_ch       (rsp_ch)
   );

endmodule

/* hw/rtl/csm_checker.sv */
`include "assert_macros.svh"

module csm_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic                                 accepted,
   input logic [csm_pkg::StateCodeWidth-1:0]   conn_state,
   input logic [csm_pkg::KindWidth-1:0]        send_kind,
   input logic [csm_pkg::SeqWidth-1:0]         send_seq,
   input logic [csm_pkg::WinWidth-1:0]         send_window,
   input logic [csm_pkg::CountWidth-1:0]       sent_count
);

   logic [csm_pkg::CountWidth-1:0] last_sent_ff, last_sent_in;
   logic                           rsp_take;
   logic                           has_frame;

   assign rsp_take  = rsp_valid && rsp_ready;
   assign has_frame = send_kind != csm_pkg::KIND_NONE;

   always_comb begin
      last_sent_in = last_sent_ff;
      if (rsp_take) begin
         last_sent_in = sent_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_sent_ff <= '0;
      end else begin
         last_sent_ff <= last_sent_in;
      end
   end

   `CSM_ASSERT_ALWAYS(a_no_word_after_reset, clock, (reset |=> !rsp_valid), "rsp valid after reset")

   `CSM_ASSERT(a_rsp_hold, clock, reset, ((rsp_valid && !rsp_ready) |=> rsp_valid), "rsp word dropped while stalled")

   `CSM_ASSERT(a_rsp_stable, clock, reset, ((rsp_valid && !rsp_ready) |=> ($stable(send_seq) && $stable(sent_count) && $stable(conn_state))), "rsp word changed while stalled")

   `CSM_ASSERT(a_sent_count_step, clock, reset, (rsp_take |-> (has_frame ? (sent_count == last_sent_ff + csm_pkg::CountWidth'(1)) : (sent_count == last_sent_ff))), "sent count does not follow sent frames")

   `CSM_ASSERT(a_reject_silent, clock, reset, ((rsp_valid && !accepted) |-> (!has_frame && send_seq == '0 && send_window == '0)), "rejected event sends a frame")

endmodule

bind connection_state_machine csm_checker u_csm_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .accepted    (rsp_ch.accepted),
   .conn_state  (rsp_ch.conn_state),
   .send_kind   (rsp_ch.send_kind),
   .send_seq    (rsp_ch.send_seq),
   .send_window (rsp_ch.send_window),
   .sent_count  (rsp_ch.sent_count)
);
